// ----- rtl/core/mrdf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the mesh relay duplicate filter.
package mrdf_pkg;

  // Field widths
  localparam int ADDR_W  = 14;
  localparam int SEQ_W   = 7;
  localparam int TYPE_W  = 4;
  localparam int TTL_W   = 4;
  localparam int ACT_W   = 3;
  localparam int KEY_W   = ADDR_W + SEQ_W;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ADDRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ADDRESS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ADDRESS_C = 2'd3;

  // Register reset values
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST     = 14'd1100;
  localparam logic [ADDR_W-1:0] GROUP_ADDRESS_A_RST = 14'd1003;
  localparam logic [ADDR_W-1:0] GROUP_ADDRESS_B_RST = 14'd1002;
  localparam logic [ADDR_W-1:0] GROUP_ADDRESS_C_RST = 14'd1001;

  // Message type that carries a location request
  localparam logic [TYPE_W-1:0] LOC_REQ_TYPE = 4'd7;

  typedef enum logic [ACT_W-1:0] {
    ACT_DELIVER   = 3'd0,
    ACT_FORWARD   = 3'd1,
    ACT_DUPLICATE = 3'd2,
    ACT_EXPIRED   = 3'd3,
    ACT_RX_ERROR  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted request
    logic step;    // advance the history scan
    logic commit;  // record the key and register the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // key found in the selected history
    logic scan_done;  // all filled entries compared
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

// ----- rtl/core/mrdf_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer that steps one request through load, history scan and commit.
module mrdf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_rx_ok,
  output logic                  in_stall,
  input  mrdf_pkg::dp_status_t  status,
  output mrdf_pkg::dp_cmd_t     cmd
);
  import mrdf_pkg::*;

  ctl_state_t state_r, state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_rx_ok ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (status.hit || status.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Leave commit as soon as the result register takes the result
  a_commit_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && status.out_free) |=> state_r == ST_IDLE)
    else $error("controller stayed in commit after result was registered");

  // A request with a receive error skips the scan
  a_rx_err_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && !in_rx_ok) |=> state_r == ST_COMMIT)
    else $error("receive error request entered the scan");

  // Hold off requests while one is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("request accepted while another is in flight");

endmodule

// ----- rtl/core/mrdf_datapath.sv -----
`timescale 1ns / 1ps
// Address match, ring histories with sequential key scan, and result register.
module mrdf_datapath #(
  parameter int HISTORY_DEPTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mrdf_pkg::dp_cmd_t                 cmd,
  output mrdf_pkg::dp_status_t              status,
  input  logic                              in_rx_ok,
  input  logic [mrdf_pkg::ADDR_W-1:0]       in_src_addr,
  input  logic [mrdf_pkg::ADDR_W-1:0]       in_dst_addr,
  input  logic [mrdf_pkg::SEQ_W-1:0]        in_seq_id,
  input  logic [mrdf_pkg::TYPE_W-1:0]       in_msg_type,
  input  logic [mrdf_pkg::TTL_W-1:0]        in_hop_ttl,
  input  logic                              cfg_we,
  input  logic [mrdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrdf_pkg::ADDR_W-1:0]       cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mrdf_pkg::ACT_W-1:0]        out_action,
  output logic [mrdf_pkg::TTL_W-1:0]        out_fwd_ttl,
  output logic                              out_location_request
);
  import mrdf_pkg::*;

  localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int MEM_D  = 2 * HISTORY_DEPTH;
  localparam int MADR_W = $clog2(MEM_D);

  // Configuration registers
  logic [ADDR_W-1:0] own_addr_r, grp_a_r, grp_b_r, grp_c_r;

  // Captured request
  logic [KEY_W-1:0]  key_r;
  logic              ring_r;      // 0 delivered history, 1 relayed history
  logic              rx_ok_r;
  logic [TYPE_W-1:0] msg_type_r;
  logic [TTL_W-1:0]  hop_ttl_r;

  // Ring state, one slot per history
  logic [IDX_W-1:0] ptr_r [2];
  logic [CNT_W-1:0] cnt_r [2];

  // Scan state
  logic [CNT_W-1:0] rd_idx_r;
  logic             cmp_vld_r;
  logic             hit_r;
  logic [KEY_W-1:0] rdata_r;

  // Both histories share one memory: delivered low, relayed high
  logic [KEY_W-1:0] hist_mem [MEM_D];

  // Result register
  logic              out_valid_r;
  action_t           out_action_r;
  logic [TTL_W-1:0]  out_fwd_ttl_r;
  logic              out_loc_r;

  logic              local_dst;
  logic [CNT_W-1:0]  cnt_sel;
  logic              issue;
  logic [MADR_W-1:0] base_addr;
  logic [MADR_W-1:0] rd_addr;
  logic [MADR_W-1:0] wr_addr;
  logic              wr_en;
  logic              out_free;
  action_t           act_nxt;
  logic [TTL_W-1:0]  ttl_nxt;
  logic              loc_nxt;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDRESS_RST;
      grp_a_r    <= GROUP_ADDRESS_A_RST;
      grp_b_r    <= GROUP_ADDRESS_B_RST;
      grp_c_r    <= GROUP_ADDRESS_C_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:     own_addr_r <= cfg_wdata;
        REG_GROUP_ADDRESS_A: grp_a_r    <= cfg_wdata;
        REG_GROUP_ADDRESS_B: grp_b_r    <= cfg_wdata;
        REG_GROUP_ADDRESS_C: grp_c_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Match destination against this node and its groups
  assign local_dst = (in_dst_addr == own_addr_r) || (in_dst_addr == grp_a_r) ||
                     (in_dst_addr == grp_b_r) || (in_dst_addr == grp_c_r);

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r      <= {in_src_addr, in_seq_id};
      ring_r     <= ~local_dst;
      rx_ok_r    <= in_rx_ok;
      msg_type_r <= in_msg_type;
      hop_ttl_r  <= in_hop_ttl;
    end
  end

  // Select the history of this request
  assign cnt_sel   = cnt_r[ring_r];
  assign base_addr = ring_r ? MADR_W'(HISTORY_DEPTH) : '0;
  assign issue     = cmd.step && (rd_idx_r < cnt_sel);
  assign rd_addr   = base_addr + MADR_W'(rd_idx_r);
  assign wr_addr   = base_addr + MADR_W'(ptr_r[ring_r]);
  assign wr_en     = cmd.commit && rx_ok_r && !hit_r;

  // Advance the scan: issue one read and compare the previous one per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else if (cmd.load) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (cmp_vld_r && (rdata_r == key_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // History memory: registered read, write at the ring pointer
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= hist_mem[rd_addr];
    end
    if (wr_en) begin
      hist_mem[wr_addr] <= key_r;
    end
  end

  // Advance ring pointer and fill count on a new key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        ptr_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (ptr_r[ring_r] == IDX_W'(HISTORY_DEPTH - 1)) begin
        ptr_r[ring_r] <= '0;
      end else begin
        ptr_r[ring_r] <= ptr_r[ring_r] + 1'b1;
      end
      if (cnt_r[ring_r] != CNT_W'(HISTORY_DEPTH)) begin
        cnt_r[ring_r] <= cnt_r[ring_r] + 1'b1;
      end
    end
  end

  // Decide the result
  always_comb begin
    act_nxt = ACT_EXPIRED;
    ttl_nxt = '0;
    loc_nxt = 1'b0;
    if (!rx_ok_r) begin
      act_nxt = ACT_RX_ERROR;
    end else if (hit_r) begin
      act_nxt = ACT_DUPLICATE;
    end else if (!ring_r) begin
      act_nxt = ACT_DELIVER;
      loc_nxt = (msg_type_r == LOC_REQ_TYPE);
    end else if (hop_ttl_r != '0) begin
      act_nxt = ACT_FORWARD;
      ttl_nxt = hop_ttl_r - 1'b1;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action_r  <= act_nxt;
      out_fwd_ttl_r <= ttl_nxt;
      out_loc_r     <= loc_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = out_action_r;
  assign out_fwd_ttl          = out_fwd_ttl_r;
  assign out_location_request = out_loc_r;

  assign status.hit       = hit_r;
  assign status.scan_done = (rd_idx_r == cnt_sel) && !cmp_vld_r;
  assign status.out_free  = out_free;

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  // A fresh request starts with a clear hit flag
  a_hit_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!hit_r && !cmp_vld_r && rd_idx_r == '0))
    else $error("scan state not cleared on load");

  // Only forwarded results carry a hop count
  a_ttl_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_FORWARD) |-> out_fwd_ttl_r == '0)
    else $error("hop count set on a result that is not forwarded");

  // Location request only on delivery
  a_loc_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_loc_r) |-> out_action_r == ACT_DELIVER)
    else $error("location request on a result that is not delivered");

endmodule

// ----- rtl/core/mesh_relay_duplicate_filter.sv -----
`timescale 1ns / 1ps
// Mesh relay duplicate filter: routes each header to deliver, forward or drop.
// Each accepted request is loaded, then scanned against the filled entries (up to HISTORY_DEPTH)
// of the selected history, stopping early on a duplicate and skipped on a receive error, then
// committed once any stalled earlier result has left the result register.
// Throughput: one request at a time; the next is accepted at the edge after the commit.
// Reset (rst_n, synchronous): histories empty, registers at their default addresses.
module mesh_relay_duplicate_filter #(
  parameter int HISTORY_DEPTH = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_rx_ok,
  input  logic [mrdf_pkg::ADDR_W-1:0]       in_src_addr,
  input  logic [mrdf_pkg::ADDR_W-1:0]       in_dst_addr,
  input  logic [mrdf_pkg::SEQ_W-1:0]        in_seq_id,
  input  logic [mrdf_pkg::TYPE_W-1:0]       in_msg_type,
  input  logic [mrdf_pkg::TTL_W-1:0]        in_hop_ttl,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mrdf_pkg::ACT_W-1:0]        out_action,
  output logic [mrdf_pkg::TTL_W-1:0]        out_fwd_ttl,
  output logic                              out_location_request,
  input  logic                              cfg_we,
  input  logic [mrdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrdf_pkg::ADDR_W-1:0]       cfg_wdata
);
  import mrdf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  mrdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_rx_ok (in_rx_ok),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  mrdf_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_rx_ok             (in_rx_ok),
    .in_src_addr          (in_src_addr),
    .in_dst_addr          (in_dst_addr),
    .in_seq_id            (in_seq_id),
    .in_msg_type          (in_msg_type),
    .in_hop_ttl           (in_hop_ttl),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_fwd_ttl          (out_fwd_ttl),
    .out_location_request (out_location_request)
  );

endmodule

// ----- tb/mesh_relay_duplicate_filter_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the mesh relay duplicate filter: routing and history checks.
module mesh_relay_duplicate_filter_test;
  import mrdf_pkg::*;

  localparam int DEPTH           = 20;
  localparam int RESET_CYCLES    = 8;
  localparam int PHASE_REQUESTS  = 305;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AFTER  = 900;
  localparam int SETTLE_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HIST_DELIVERED  = 0;
  localparam int HIST_RELAYED    = 1;
  localparam int RECENT_KEEP     = 48;

  typedef struct packed {
    logic              rx_ok;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [SEQ_W-1:0]  seq_id;
    logic [TYPE_W-1:0] msg_type;
    logic [TTL_W-1:0]  hop_ttl;
  } rx_header_t;

  typedef struct packed {
    action_t          action;
    logic [TTL_W-1:0] fwd_ttl;
    logic             loc_req;
  } verdict_t;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE} sink_mode_t;

  // Routing predictor with its own address registers and key histories
  class dedup_scoreboard;
    logic [ADDR_W-1:0] own_addr, grp_a, grp_b, grp_c;
    logic [KEY_W-1:0]  hist_key [2][DEPTH];
    bit                hist_vld [2][DEPTH];
    int                hist_ptr [2];
    verdict_t          verdict_q [$];
    int                mismatches;

    function void clear();
      own_addr = OWN_ADDRESS_RST;
      grp_a    = GROUP_ADDRESS_A_RST;
      grp_b    = GROUP_ADDRESS_B_RST;
      grp_c    = GROUP_ADDRESS_C_RST;
      for (int h = 0; h < 2; h++) begin
        hist_ptr[h] = 0;
        for (int i = 0; i < DEPTH; i++) hist_vld[h][i] = 1'b0;
      end
      verdict_q.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      case (idx)
        REG_OWN_ADDRESS:     own_addr = val;
        REG_GROUP_ADDRESS_A: grp_a = val;
        REG_GROUP_ADDRESS_B: grp_b = val;
        REG_GROUP_ADDRESS_C: grp_c = val;
        default: ;
      endcase
    endfunction

    // Look the key up; record it at the ring pointer when it is new
    function bit key_seen_or_record(int h, logic [KEY_W-1:0] key);
      for (int i = 0; i < DEPTH; i++)
        if (hist_vld[h][i] && hist_key[h][i] == key) return 1'b1;
      hist_key[h][hist_ptr[h]] = key;
      hist_vld[h][hist_ptr[h]] = 1'b1;
      hist_ptr[h] = (hist_ptr[h] == DEPTH - 1) ? 0 : hist_ptr[h] + 1;
      return 1'b0;
    endfunction

    function verdict_t route_header(rx_header_t hd);
      verdict_t         v;
      logic [KEY_W-1:0] key;
      v.action  = ACT_RX_ERROR;
      v.fwd_ttl = '0;
      v.loc_req = 1'b0;
      key = {hd.src_addr, hd.seq_id};
      // Drop bad receptions without touching either history
      if (!hd.rx_ok) return v;
      if (hd.dst_addr == own_addr || hd.dst_addr == grp_a ||
          hd.dst_addr == grp_b || hd.dst_addr == grp_c) begin
        if (key_seen_or_record(HIST_DELIVERED, key)) begin
          v.action = ACT_DUPLICATE;
        end else begin
          v.action  = ACT_DELIVER;
          v.loc_req = (hd.msg_type == LOC_REQ_TYPE);
        end
      end else if (key_seen_or_record(HIST_RELAYED, key)) begin
        v.action = ACT_DUPLICATE;
      end else if (hd.hop_ttl != 0) begin
        v.action  = ACT_FORWARD;
        v.fwd_ttl = hd.hop_ttl - 1'b1;
      end else begin
        v.action = ACT_EXPIRED;
      end
      return v;
    endfunction

    function void note_header(rx_header_t hd);
      verdict_q.push_back(route_header(hd));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    function void check_verdict(logic [ACT_W-1:0] act, logic [TTL_W-1:0] ttl, logic loc);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag($sformatf("result with no request pending: action=%0d fwd_ttl=%0d loc=%0b",
                       act, ttl, loc));
        return;
      end
      want = verdict_q.pop_front();
      if (act !== want.action || ttl !== want.fwd_ttl || loc !== want.loc_req)
        flag($sformatf({"expected action=%0d fwd_ttl=%0d loc=%0b, ",
                        "got action=%0d fwd_ttl=%0d loc=%0b"},
                       want.action, want.fwd_ttl, want.loc_req, act, ttl, loc));
    endfunction

    function int outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_rx_ok;
  logic [ADDR_W-1:0] in_src_addr;
  logic [ADDR_W-1:0] in_dst_addr;
  logic [SEQ_W-1:0]  in_seq_id;
  logic [TYPE_W-1:0] in_msg_type;
  logic [TTL_W-1:0]  in_hop_ttl;
  logic              out_valid;
  logic              out_stall;
  logic [ACT_W-1:0]  out_action;
  logic [TTL_W-1:0]  out_fwd_ttl;
  logic              out_location_request;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  dedup_scoreboard sb;
  int              headers_taken = 0;
  int              quiet_cycles = 0;
  int              burst_left = 0;
  rx_header_t      recent_q [$];

  mesh_relay_duplicate_filter #(.HISTORY_DEPTH(DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_ok             (in_rx_ok),
    .in_src_addr          (in_src_addr),
    .in_dst_addr          (in_dst_addr),
    .in_seq_id            (in_seq_id),
    .in_msg_type          (in_msg_type),
    .in_hop_ttl           (in_hop_ttl),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action           (out_action),
    .out_fwd_ttl          (out_fwd_ttl),
    .out_location_request (out_location_request),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predict each accepted request
  always @(posedge clk) begin : request_monitor
    rx_header_t hd;
    if (rst_n && in_valid && !in_stall) begin
      hd.rx_ok    = in_rx_ok;
      hd.src_addr = in_src_addr;
      hd.dst_addr = in_dst_addr;
      hd.seq_id   = in_seq_id;
      hd.msg_type = in_msg_type;
      hd.hop_ttl  = in_hop_ttl;
      sb.note_header(hd);
      headers_taken++;
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_action, out_fwd_ttl, out_location_request);
  end

  // Abort when neither channel nor the register port moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mesh_relay_duplicate_filter_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result stall pattern, with one long hold-off to back the block up
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    bit         held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && headers_taken >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 80);
      repeat (span) begin
        case (mode)
          SINK_OPEN:  out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic rx_header_t hdr(logic rx, logic [ADDR_W-1:0] src,
                                     logic [ADDR_W-1:0] dst, logic [SEQ_W-1:0] seq,
                                     logic [TYPE_W-1:0] typ, logic [TTL_W-1:0] ttl);
    rx_header_t hd;
    hd.rx_ok    = rx;
    hd.src_addr = src;
    hd.dst_addr = dst;
    hd.seq_id   = seq;
    hd.msg_type = typ;
    hd.hop_ttl  = ttl;
    return hd;
  endfunction

  // Hold the request until the block takes it
  task automatic offer_header(input rx_header_t hd);
    in_valid    <= 1'b1;
    in_rx_ok    <= hd.rx_ok;
    in_src_addr <= hd.src_addr;
    in_dst_addr <= hd.dst_addr;
    in_seq_id   <= hd.seq_id;
    in_msg_type <= hd.msg_type;
    in_hop_ttl  <= hd.hop_ttl;
    do @(posedge clk); while (in_stall);
  endtask

  // Insert a random gap at the end of each burst
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_addresses(input logic [ADDR_W-1:0] own, grp_a, grp_b, grp_c);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [ADDR_W-1:0]    val [4];
    idx = '{REG_OWN_ADDRESS, REG_GROUP_ADDRESS_A, REG_GROUP_ADDRESS_B, REG_GROUP_ADDRESS_C};
    val = '{own, grp_a, grp_b, grp_c};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Fresh headers mixed with echoes of recent ones, so duplicates and evictions occur
  function automatic rx_header_t make_header();
    rx_header_t hd;
    if (recent_q.size() != 0 && $urandom_range(0, 99) < 35) begin
      hd = recent_q[$urandom_range(0, recent_q.size() - 1)];
      hd.hop_ttl  = TTL_W'($urandom);
      hd.msg_type = ($urandom_range(0, 2) == 0) ? LOC_REQ_TYPE : TYPE_W'($urandom);
      if ($urandom_range(0, 4) == 0) hd.dst_addr = ADDR_W'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       hd.src_addr = ADDR_W'($urandom_range(0, 7));
        1:       hd.src_addr = ADDR_W'($urandom_range(0, 9999));
        default: hd.src_addr = ADDR_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       hd.seq_id = SEQ_W'($urandom_range(0, 3));
        1:       hd.seq_id = SEQ_W'($urandom_range(0, 99));
        default: hd.seq_id = SEQ_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       hd.dst_addr = sb.own_addr;
        1:       hd.dst_addr = sb.grp_a;
        2:       hd.dst_addr = sb.grp_b;
        3:       hd.dst_addr = sb.grp_c;
        4:       hd.dst_addr = ADDR_W'($urandom_range(0, 9999));
        default: hd.dst_addr = ADDR_W'($urandom);
      endcase
      hd.msg_type = ($urandom_range(0, 3) == 0) ? LOC_REQ_TYPE : TYPE_W'($urandom);
      hd.hop_ttl  = ($urandom_range(0, 4) == 0) ? '0 : TTL_W'($urandom);
    end
    hd.rx_ok = ($urandom_range(0, 9) != 0);
    return hd;
  endfunction

  task automatic run_random(input int count);
    rx_header_t hd;
    repeat (count) begin
      hd = make_header();
      pace_sender();
      offer_header(hd);
      recent_q.push_back(hd);
      if (recent_q.size() > RECENT_KEEP) void'(recent_q.pop_front());
    end
  endtask

  initial begin : stimulus
    rx_header_t directed [$];
    sb = new;
    sb.clear();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_ok    <= 1'b0;
    in_src_addr <= '0;
    in_dst_addr <= '0;
    in_seq_id   <= '0;
    in_msg_type <= '0;
    in_hop_ttl  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_OWN_ADDRESS;
    cfg_wdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests against the reset addresses
    directed = '{
      hdr(1'b0, 14'd16383, 14'd16383, 7'd127, 4'd15, 4'd15),  // receive error
      hdr(1'b1, 14'd0,     14'd1100,  7'd0,   4'd7,  4'd0),   // deliver, location
      hdr(1'b1, 14'd0,     14'd1100,  7'd0,   4'd3,  4'd9),   // duplicate delivery
      hdr(1'b1, 14'd16383, 14'd1003,  7'd127, 4'd15, 4'd15),  // group a
      hdr(1'b1, 14'd9999,  14'd1002,  7'd99,  4'd0,  4'd0),   // group b
      hdr(1'b1, 14'd9999,  14'd1001,  7'd98,  4'd7,  4'd9),   // group c, location
      hdr(1'b1, 14'd9999,  14'd1001,  7'd99,  4'd7,  4'd0),   // duplicate across groups
      hdr(1'b1, 14'd1234,  14'd9999,  7'd5,   4'd1,  4'd9),   // forward
      hdr(1'b1, 14'd1234,  14'd0,     7'd6,   4'd9,  4'd15),  // forward, ttl at top of range
      hdr(1'b1, 14'd1234,  14'd16383, 7'd7,   4'd2,  4'd0),   // expired, key still kept
      hdr(1'b1, 14'd1234,  14'd16383, 7'd7,   4'd2,  4'd5),   // duplicate of expired
      hdr(1'b1, 14'd0,     14'd5,     7'd0,   4'd7,  4'd1),   // relay uses its own history
      hdr(1'b0, 14'd42,    14'd1100,  7'd42,  4'd7,  4'd3),   // error leaves key unseen
      hdr(1'b1, 14'd42,    14'd1100,  7'd42,  4'd7,  4'd3),
      hdr(1'b1, 14'd42,    14'd1099,  7'd42,  4'd7,  4'd1),
      hdr(1'b1, 14'd42,    14'd1101,  7'd42,  4'd7,  4'd1),
      hdr(1'b1, 14'd5461,  14'd1100,  7'd85,  4'd10, 4'd10),
      hdr(1'b1, 14'd10922, 14'd2,     7'd42,  4'd5,  4'd10),
      hdr(1'b0, 14'd0,     14'd0,     7'd0,   4'd0,  4'd0)
    };
    foreach (directed[i]) offer_header(directed[i]);
    run_random(PHASE_REQUESTS);

    // Walk the address registers through their extremes
    drain_results();
    program_addresses(14'd0, 14'd9999, 14'd16383, 14'd5555);
    run_random(PHASE_REQUESTS);
    drain_results();
    program_addresses(14'd9999, 14'd0, 14'd0, 14'd0);
    run_random(PHASE_REQUESTS);
    drain_results();
    program_addresses(14'd16383, 14'd10922, 14'd5461, 14'd1100);
    run_random(PHASE_REQUESTS);
    drain_results();
    program_addresses(ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                      ADDR_W'($urandom));
    run_random(PHASE_REQUESTS);
    drain_results();
    program_addresses(OWN_ADDRESS_RST, GROUP_ADDRESS_A_RST, GROUP_ADDRESS_B_RST,
                      GROUP_ADDRESS_C_RST);
    run_random(PHASE_REQUESTS);

    // Drain and let the block settle before the verdict
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.mismatches == 0)
      $display("mesh_relay_duplicate_filter_test: done, clean");
    else
      $display("mesh_relay_duplicate_filter_test: done, errors");
    $finish;
  end

endmodule
